// ===== design/tmc_pkg.sv =====
package tmc_pkg;

  // Operation codes carried by each input word.
  typedef enum logic [3:0] {
    OP_ROT_X   = 4'd0,
    OP_ROT_Y   = 4'd1,
    OP_ROT_Z   = 4'd2,
    OP_TRANS_X = 4'd3,
    OP_TRANS_Y = 4'd4,
    OP_TRANS_Z = 4'd5,
    OP_SCALE_X = 4'd6,
    OP_SCALE_Y = 4'd7,
    OP_SCALE_Z = 4'd8,
    OP_SCALE_U = 4'd9
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_EMIT
  } state_e;

  localparam int unsigned CordicFrac = 30;
  localparam int unsigned AtanDepth  = 30;
  localparam logic signed [63:0] CordicGain = 64'sd652032874;
  localparam logic signed [63:0] PiFix      = 64'sd3373259426;
  localparam logic signed [63:0] HalfPiFix  = 64'sd1686629713;

  // Arctangent table, round(atan(2^-i) * 2^30).
  function automatic logic signed [63:0] atan_lut(input logic [4:0] idx);
    logic signed [63:0] v;
    case (idx)
      5'd0:  v = 64'sd843314857;
      5'd1:  v = 64'sd497837829;
      5'd2:  v = 64'sd263043837;
      5'd3:  v = 64'sd133525159;
      5'd4:  v = 64'sd67021687;
      5'd5:  v = 64'sd33543516;
      5'd6:  v = 64'sd16775851;
      5'd7:  v = 64'sd8388437;
      5'd8:  v = 64'sd4194283;
      5'd9:  v = 64'sd2097149;
      default: v = 64'sd1 <<< (5'd30 - idx);
    endcase
    return v;
  endfunction

  // Saturate a wide value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Start and angle handed from the sequencer to the CORDIC.
  typedef struct packed {
    logic        start;
    logic [31:0] amount;
  } tmc_ctrl_t;

endpackage

// ===== design/tmc_cordic.sv =====
module tmc_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int Steps = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int Sh = 30 - FRAC_BITS;

  logic signed [63:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               flip_q, flip_d, busy_q, busy_d;
  logic [4:0]         i_q, i_d;
  logic signed [63:0] z0, dx, dy, xf, yf;

  // One rotation per cycle on the shared add/shift unit; a closing step then
  // presents the finished result.
  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; flip_d = flip_q; busy_d = busy_q; i_d = i_q;
    z0 = 64'(angle_i) <<< Sh;
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    if (start_i) begin
      if (z0 > tmc_pkg::PiFix) z0 = tmc_pkg::PiFix;
      if (z0 < -tmc_pkg::PiFix) z0 = -tmc_pkg::PiFix;
      flip_d = 1'b0;
      if (z0 > tmc_pkg::HalfPiFix) begin
        z0 = z0 - tmc_pkg::PiFix; flip_d = 1'b1;
      end else if (z0 < -tmc_pkg::HalfPiFix) begin
        z0 = z0 + tmc_pkg::PiFix; flip_d = 1'b1;
      end
      x_d = tmc_pkg::CordicGain; y_d = '0; z_d = z0; i_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (32'(i_q) == Steps) begin
        busy_d = 1'b0;
      end else begin
        if (z_q >= 0) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - tmc_pkg::atan_lut(i_q);
        end else begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + tmc_pkg::atan_lut(i_q);
        end
        i_d = i_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; flip_q <= flip_d;
  end

  // Final sign fix and rounding back to the entry format.
  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign cos_o = tmc_pkg::sat32(66'((xf + (64'sd1 <<< (Sh - 1))) >>> Sh));
  assign sin_o = tmc_pkg::sat32(66'((yf + (64'sd1 <<< (Sh - 1))) >>> Sh));
  assign done_o = busy_q && (32'(i_q) == Steps);

endmodule

// ===== design/tmc_mac.sv =====
module tmc_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] p_o
);

  logic signed [63:0] prod;
  logic signed [64:0] rnd;

  // Shared fixed-point multiplier: round half up, then saturate.
  always_comb begin
    prod = 64'(a_i) * 64'(b_i);
    rnd  = (65'(prod) + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    p_o  = tmc_pkg::sat32(66'(rnd));
  end

endmodule

// ===== design/transform_matrix_composer_top.sv =====
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid_i/in_stall_o | operation_i, amount_i, final_op_i
// out     | output    | out_valid_o/out_stall_i | column_index_o, row0..3_o, last_column_o
// Rotations first compute sine/cosine on the CORDIC, then take 16 multiply steps;
// translations and axis scales take 4 multiply steps, the uniform scale 12 (one
// product per cycle), unused codes none. Every operation then ends in a closing step.
// A final word then emits four column words, one per accepted output cycle.
// Reset restores the identity matrix and idles the sequencer.
// in_stall_o is high from acceptance until the sequencer is idle again.
module transform_matrix_composer_top #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         operation_i,
  input  logic signed [31:0] amount_i,
  input  logic               final_op_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         column_index_o,
  output logic signed [31:0] row0_o,
  output logic signed [31:0] row1_o,
  output logic signed [31:0] row2_o,
  output logic signed [31:0] row3_o,
  output logic               last_column_o
);

  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  tmc_pkg::state_e    state_q, state_d;
  logic signed [31:0] m_q [16];
  logic signed [31:0] m_d [16];
  logic [3:0]         op_q, op_d;
  logic signed [31:0] amt_q, amt_d, s_q, s_d, c_q, c_d, p0_q, p0_d, p1_q, p1_d;
  logic               fin_q, fin_d;
  logic [4:0]         k_q, k_d;
  logic [1:0]         col_q, col_d;
  logic               cdone, accept;
  logic signed [31:0] csin, ccos, ma, mb, prod;
  logic [1:0]         ca, cb, row;
  logic [4:0]         nsteps;
  tmc_pkg::tmc_ctrl_t ctrl;

  assign accept = in_valid_i && !in_stall_o;
  assign ctrl.start  = accept && (operation_i == tmc_pkg::OP_ROT_X ||
                       operation_i == tmc_pkg::OP_ROT_Y || operation_i == tmc_pkg::OP_ROT_Z);
  assign ctrl.amount = amount_i;

  tmc_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(ctrl.start), .angle_i(ctrl.amount),
    .done_o(cdone), .sin_o(csin), .cos_o(ccos)
  );

  tmc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (.a_i(ma), .b_i(mb), .p_o(prod));

  // Rotation column pair.
  always_comb begin
    case (op_q)
      tmc_pkg::OP_ROT_X: begin ca = 2'd1; cb = 2'd2; end
      tmc_pkg::OP_ROT_Y: begin ca = 2'd2; cb = 2'd0; end
      default:           begin ca = 2'd0; cb = 2'd1; end
    endcase
  end

  assign row = k_q[3:2];

  // Step counts per operation class.
  always_comb begin
    case (op_q)
      tmc_pkg::OP_ROT_X, tmc_pkg::OP_ROT_Y, tmc_pkg::OP_ROT_Z: nsteps = 5'd16;
      tmc_pkg::OP_SCALE_U: nsteps = 5'd12;
      tmc_pkg::OP_TRANS_X, tmc_pkg::OP_TRANS_Y, tmc_pkg::OP_TRANS_Z,
      tmc_pkg::OP_SCALE_X, tmc_pkg::OP_SCALE_Y, tmc_pkg::OP_SCALE_Z: nsteps = 5'd4;
      default: nsteps = 5'd0;
    endcase
  end

  // Multiplier operand select. Rotation step k: row k/4, phase k%4 gives
  // c*a, s*b, c*b, s*a. The new a is held in p0 and c*b in p1 so that both
  // entries of the row are written together on the last phase.
  always_comb begin
    ma = amt_q; mb = '0;
    case (op_q)
      tmc_pkg::OP_ROT_X, tmc_pkg::OP_ROT_Y, tmc_pkg::OP_ROT_Z: begin
        case (k_q[1:0])
          2'd0:    begin ma = c_q; mb = m_q[{ca, row}]; end
          2'd1:    begin ma = s_q; mb = m_q[{cb, row}]; end
          2'd2:    begin ma = c_q; mb = m_q[{cb, row}]; end
          default: begin ma = s_q; mb = m_q[{ca, row}]; end
        endcase
      end
      tmc_pkg::OP_TRANS_X, tmc_pkg::OP_TRANS_Y, tmc_pkg::OP_TRANS_Z:
        mb = m_q[{2'(op_q - 4'd3), k_q[1:0]}];
      tmc_pkg::OP_SCALE_X, tmc_pkg::OP_SCALE_Y, tmc_pkg::OP_SCALE_Z:
        mb = m_q[{2'(op_q - 4'd6), k_q[1:0]}];
      default: mb = m_q[k_q[3:0]];
    endcase
  end

  // Sequencer and matrix update.
  always_comb begin
    state_d = state_q; m_d = m_q; op_d = op_q; amt_d = amt_q; fin_d = fin_q;
    k_d = k_q; col_d = col_q; s_d = s_q; c_d = c_q; p0_d = p0_q; p1_d = p1_q;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      tmc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d = operation_i; amt_d = amount_i; fin_d = final_op_i; k_d = '0;
          state_d = ctrl.start ? tmc_pkg::ST_CORDIC : tmc_pkg::ST_MUL;
        end
      end
      tmc_pkg::ST_CORDIC: begin
        if (cdone) state_d = tmc_pkg::ST_MUL;
        s_d = csin; c_d = ccos;
      end
      tmc_pkg::ST_MUL: begin
        if (k_q >= nsteps) begin
          col_d = '0;
          state_d = fin_q ? tmc_pkg::ST_EMIT : tmc_pkg::ST_IDLE;
        end else begin
          case (op_q)
            tmc_pkg::OP_ROT_X, tmc_pkg::OP_ROT_Y, tmc_pkg::OP_ROT_Z: begin
              case (k_q[1:0])
                2'd0: p0_d = prod;
                2'd1: p0_d = tmc_pkg::sat32(66'(p0_q) + 66'(prod));
                2'd2: p1_d = prod;
                default: begin
                  m_d[{ca, row}] = p0_q;
                  m_d[{cb, row}] = tmc_pkg::sat32(66'(p1_q) - 66'(prod));
                end
              endcase
            end
            tmc_pkg::OP_TRANS_X, tmc_pkg::OP_TRANS_Y, tmc_pkg::OP_TRANS_Z:
              m_d[{2'd3, k_q[1:0]}] = tmc_pkg::sat32(66'(m_q[{2'd3, k_q[1:0]}]) + 66'(prod));
            tmc_pkg::OP_SCALE_X, tmc_pkg::OP_SCALE_Y, tmc_pkg::OP_SCALE_Z:
              m_d[{2'(op_q - 4'd6), k_q[1:0]}] = prod;
            default: m_d[k_q[3:0]] = prod;
          endcase
          k_d = k_q + 5'd1;
        end
      end
      tmc_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          col_d = col_q + 2'd1;
          if (col_q == 2'd3) begin
            state_d = tmc_pkg::ST_IDLE;
            for (int i = 0; i < 16; i++) m_d[i] = (i % 5 == 0) ? One : '0;
          end
        end
      end
      default: state_d = tmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmc_pkg::ST_IDLE;
      k_q     <= '0;
      col_q   <= '0;
      for (int i = 0; i < 16; i++) m_q[i] <= (i % 5 == 0) ? One : '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      col_q   <= col_d;
      m_q     <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; amt_q <= amt_d; fin_q <= fin_d;
    s_q <= s_d; c_q <= c_d; p0_q <= p0_d; p1_q <= p1_d;
  end

  // Output word from the held matrix.
  assign column_index_o = col_q;
  assign row0_o = m_q[{col_q, 2'd0}];
  assign row1_o = m_q[{col_q, 2'd1}];
  assign row2_o = m_q[{col_q, 2'd2}];
  assign row3_o = m_q[{col_q, 2'd3}];
  assign last_column_o = (col_q == 2'd3);

  // The input side is closed while columns are emitted.
  a_no_in_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during emit");

  // Column numbers advance by one after each taken word.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_column_o) |=>
      (column_index_o == $past(column_index_o) + 2'd1)) else $error("column skip");

  // After the last column the matrix is back to identity.
  a_reset_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_column_o) |=>
      (m_q[0] == One && m_q[1] == '0 && !out_valid_o)) else $error("no identity");

endmodule
